### rtl/fcwt_pkg.sv
// Shared types and constants for the flow control window tracker.
`timescale 1ns / 1ps

package fcwt_pkg;

    localparam int WIN_W = 31;
    localparam logic [WIN_W-1:0] WIN_RESET = 31'd65535;

    typedef logic [WIN_W-1:0] win_t;

    typedef enum logic [1:0] {
        OP_CONSUME = 2'd0,
        OP_ADD     = 2'd1,
        OP_QUERY   = 2'd2,
        OP_ADJUST  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        op_t                opcode;
        logic               is_recv;
        logic               has_stream;
        logic [3:0]         stream_slot;
        logic [31:0]        amount;
        logic signed [31:0] delta;
    } in_t;

    typedef struct packed {
        logic ok;
        win_t available;
    } out_t;

    // One stream slot: send and receive windows side by side.
    typedef struct packed {
        win_t send;
        win_t recv;
    } slot_word_t;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic execute;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

endpackage

### rtl/flow_control_window_tracker.sv
// Top level of the flow control credit window tracker.
// Flow: a taken request is read from the stream RAM, then executed into the output register, which offers the result.
// A new request is taken only after the previous one has executed, set by the read-modify-write of the stream RAM.
// A result waiting in the output register does not block intake of the next request.
// Reset: asynchronous, active low; the connection windows load 65535 at once, then a
// clearing pass writes 65535 to every stream slot with in_ready low.
`timescale 1ns / 1ps

module flow_control_window_tracker #(
    parameter int          NUM_STREAMS = 16,
    parameter int unsigned MAX_WINDOW  = 2147483647
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  fcwt_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output fcwt_pkg::out_t  out_data
);

    import fcwt_pkg::*;

    // Command and status between the controller and the datapath.
    cmd_t    cmd;
    status_t status;

    // Controller: clearing pass after reset, request intake, and the execute
    // step that waits until the output register can take the result.
    fcwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: connection window registers, per-stream window RAM (send and
    // receive packed in one word), the consume/add/query/adjust arithmetic and
    // the output register.
    fcwt_dp #(
        .NUM_STREAMS(NUM_STREAMS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .in_data (in_data),
        .out_data(out_data)
    );

endmodule

### rtl/fcwt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module fcwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/fcwt_ctrl.sv
// Controller for the window tracker: clearing pass, request intake, execute.
`timescale 1ns / 1ps

module fcwt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  fcwt_pkg::status_t status,
    output fcwt_pkg::cmd_t    cmd
);

    import fcwt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Hold until the output register is free or being drained.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        out_valid_next = cmd.execute | (out_valid_reg & ~out_ready);
    end

    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

    a_no_intake_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == ST_EXEC && !in_ready))
        else $error("request intake while previous request in flight");

    a_exec_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> out_valid_reg)
        else $error("executed request produced no result");

endmodule

### rtl/fcwt_dp.sv
// Datapath for the window tracker: connection windows, stream window RAM, arithmetic.
`timescale 1ns / 1ps

module fcwt_dp #(
    parameter int          NUM_STREAMS = 16,
    parameter int unsigned MAX_WINDOW  = 2147483647
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fcwt_pkg::cmd_t    cmd,
    output fcwt_pkg::status_t status,
    input  fcwt_pkg::in_t     in_data,
    output fcwt_pkg::out_t    out_data
);

    import fcwt_pkg::*;

    localparam int SLOT_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int NUM_CODES = 16;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_STREAMS - 1);
    localparam logic [32:0] MAX_W33 = 33'(MAX_WINDOW);

    // Slot number folding: stream_slot modulo NUM_STREAMS as a constant table.
    logic [SLOT_W-1:0] slot_lut [NUM_CODES];
    genvar g;
    generate
        for (g = 0; g < NUM_CODES; g++)
        begin : g_slot
            assign slot_lut[g] = SLOT_W'(g % NUM_STREAMS);
        end
    endgenerate

    in_t               req_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] clr_cnt_reg;
    win_t              conn_send_reg;
    win_t              conn_recv_reg;
    out_t              out_reg;

    slot_word_t        rd_word;
    slot_word_t        wr_word;
    logic              ram_wr_en;
    logic [SLOT_W-1:0] ram_wr_addr;
    slot_word_t        ram_wr_data;

    win_t              cw;
    win_t              sw;
    win_t              tw;
    win_t              amt31;
    logic [32:0]       add_sum;
    logic signed [33:0] adj_sum;
    logic              res_ok;
    win_t              res_avail;
    logic              conn_wr;
    logic              str_wr;
    win_t              conn_val;
    win_t              str_val;

    fcwt_ram #(
        .WIDTH ($bits(slot_word_t)),
        .DEPTH (NUM_STREAMS),
        .ADDR_W(SLOT_W)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (cmd.accept),
        .rd_addr(slot_lut[in_data.stream_slot]),
        .rd_data(rd_word)
    );

    always_comb
    begin
        cw      = req_reg.is_recv ? conn_recv_reg : conn_send_reg;
        sw      = req_reg.is_recv ? rd_word.recv : rd_word.send;
        tw      = req_reg.has_stream ? sw : cw;
        amt31   = req_reg.amount[WIN_W-1:0];
        add_sum = {2'b00, tw} + {1'b0, req_reg.amount};
        adj_sum = $signed({3'b000, tw})
                + $signed({{2{req_reg.delta[31]}}, req_reg.delta});

        res_ok    = 1'b0;
        res_avail = '0;
        conn_wr   = 1'b0;
        str_wr    = 1'b0;
        conn_val  = cw - amt31;
        str_val   = sw - amt31;

        case (req_reg.opcode)
            OP_CONSUME:
            begin
                res_ok  = !req_reg.amount[31] && (amt31 <= cw)
                        && (!req_reg.has_stream || (amt31 <= sw));
                conn_wr = res_ok;
                str_wr  = res_ok && req_reg.has_stream;
            end
            OP_ADD:
            begin
                res_ok   = (req_reg.amount != 32'd0) && (add_sum <= MAX_W33);
                conn_val = add_sum[WIN_W-1:0];
                str_val  = add_sum[WIN_W-1:0];
                conn_wr  = res_ok && !req_reg.has_stream;
                str_wr   = res_ok && req_reg.has_stream;
            end
            OP_QUERY:
            begin
                res_ok    = 1'b1;
                res_avail = (req_reg.has_stream && (rd_word.send < conn_send_reg))
                          ? rd_word.send : conn_send_reg;
            end
            OP_ADJUST:
            begin
                if (req_reg.delta == 32'sd0)
                begin
                    res_ok = 1'b1;
                end
                else
                begin
                    res_ok   = !adj_sum[33] && (adj_sum[32:0] <= MAX_W33);
                    conn_val = adj_sum[WIN_W-1:0];
                    str_val  = adj_sum[WIN_W-1:0];
                    conn_wr  = res_ok && !req_reg.has_stream;
                    str_wr   = res_ok && req_reg.has_stream;
                end
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase

        // Replace only the selected half of the slot word.
        wr_word = rd_word;
        if (req_reg.is_recv)
        begin
            wr_word.recv = str_val;
        end
        else
        begin
            wr_word.send = str_val;
        end

        if (cmd.clear_step)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_reg;
            ram_wr_data = '{send: WIN_RESET, recv: WIN_RESET};
        end
        else
        begin
            ram_wr_en   = cmd.execute && str_wr;
            ram_wr_addr = slot_reg;
            ram_wr_data = wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            conn_send_reg <= WIN_RESET;
            conn_recv_reg <= WIN_RESET;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.execute && conn_wr)
            begin
                if (req_reg.is_recv)
                begin
                    conn_recv_reg <= conn_val;
                end
                else
                begin
                    conn_send_reg <= conn_val;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg  <= in_data;
            slot_reg <= slot_lut[in_data.stream_slot];
        end
        if (cmd.execute)
        begin
            out_reg.ok        <= res_ok;
            out_reg.available <= res_avail;
        end
    end

    assign status.clear_last = (clr_cnt_reg == LAST_SLOT);
    assign out_data          = out_reg;

    a_fail_keeps_conn: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && !res_ok) |=>
            (conn_send_reg == $past(conn_send_reg)
             && conn_recv_reg == $past(conn_recv_reg)))
        else $error("failed request changed a connection window");

    a_query_side_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && req_reg.opcode == OP_QUERY) |-> (res_ok && !ram_wr_en && !conn_wr))
        else $error("query changed state or failed");

    a_avail_only_query: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && req_reg.opcode != OP_QUERY) |=> (out_reg.available == '0))
        else $error("nonzero available on a non-query request");

endmodule
